// ===== design/msad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msad_pkg
// Shared types, widths and coefficient tables for the MS ADPCM block decoder.
// ----------------------------------------------------------------------------
package msad_pkg;

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 11;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 1;

  localparam logic [15:0] MONO_HDR_LEN   = 16'd7;
  localparam logic [15:0] STEREO_HDR_LEN = 16'd14;
  localparam logic [15:0] ALIGN_RESET    = 16'd1024;
  localparam logic [2:0]  PRED_MAX       = 3'd6;
  localparam logic [31:0] DELTA_FLOOR    = 32'd16;

  typedef enum logic [0:0] {
    CFG_STEREO_MODE = 1'b0,
    CFG_BLOCK_ALIGN = 1'b1
  } msad_cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR0,
    ST_HDR1,
    ST_NA,
    ST_OB,
    ST_MD,
    ST_TD,
    ST_UPD,
    ST_EMIT
  } msad_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_block;
  } msad_in_item_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               last_of_run;
  } msad_out_item_t;

  function automatic logic signed [MUL_B_W-1:0] coef_a(input logic [2:0] pred);
    logic signed [MUL_B_W-1:0] c;
    unique case (pred)
      3'd0:    c = 11'sd256;
      3'd1:    c = 11'sd512;
      3'd2:    c = 11'sd0;
      3'd3:    c = 11'sd192;
      3'd4:    c = 11'sd240;
      3'd5:    c = 11'sd460;
      default: c = 11'sd392;
    endcase
    return c;
  endfunction

  function automatic logic signed [MUL_B_W-1:0] coef_b(input logic [2:0] pred);
    logic signed [MUL_B_W-1:0] c;
    unique case (pred)
      3'd0:    c = 11'sd0;
      3'd1:    c = -11'sd256;
      3'd2:    c = 11'sd0;
      3'd3:    c = 11'sd64;
      3'd4:    c = 11'sd0;
      3'd5:    c = -11'sd208;
      default: c = -11'sd232;
    endcase
    return c;
  endfunction

  function automatic logic signed [MUL_B_W-1:0] adapt_step(input logic [3:0] code);
    logic signed [MUL_B_W-1:0] c;
    unique case (code)
      4'd4, 4'd12: c = 11'sd307;
      4'd5, 4'd11: c = 11'sd409;
      4'd6, 4'd10: c = 11'sd512;
      4'd7, 4'd9:  c = 11'sd614;
      4'd8:        c = 11'sd768;
      default:     c = 11'sd230;
    endcase
    return c;
  endfunction

endpackage

// ===== design/msad_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msad_mul
// Shared signed 32 x 11 multiplier with a registered product.
// ----------------------------------------------------------------------------
module msad_mul
  import msad_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] mul_a,
  input  logic signed [MUL_B_W-1:0] mul_b,
  output logic signed [PROD_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

endmodule

// ===== design/ms_adpcm_block_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ms_adpcm_block_decoder
// MS ADPCM block decoder taking one stream byte per item.
// ----------------------------------------------------------------------------
// Header bytes are accepted while the block is idle; after the last header
// byte the block loads the two header frames, the older samples and then the
// newer, into the output register in turn. For a data byte, each 4-bit code
// makes four passes through the single shared 32 x 11 multiplier (two
// predictor products, the code times delta and the delta adaptation
// product) and one state update, and each frame is then loaded into the
// output register: one frame per byte in stereo, one per code in mono. A
// frame is loaded only once the output register is free. The input is
// stalled for the whole of that sequence, and a frame waits in the output
// register while the block goes on to its next step.
module ms_adpcm_block_decoder
  import msad_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  msad_in_item_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output msad_out_item_t out_data,
  input  logic           cfg_we,
  input  logic [0:0]     cfg_index,
  input  logic [15:0]    cfg_wdata
);

  localparam logic signed [ACC_W-1:0] SAMP_MIN = -ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] SAMP_MAX = ACC_W'(32767);
  localparam logic signed [PROD_W-9:0] DMAX = (PROD_W-8)'(33'h0_7FFF_FFFF);
  localparam logic signed [PROD_W-9:0] DMIN = (PROD_W-8)'(DELTA_FLOOR);

  logic               stereo_r;
  logic [15:0]        align_r;
  logic [15:0]        pos_r;
  logic [7:0]         hold_r;
  logic [2:0]         pred_r  [2];
  logic signed [31:0] delta_r [2];
  logic signed [15:0] newer_r [2];
  logic signed [15:0] older_r [2];

  msad_state_t        state_r, state_nxt;
  logic               code_idx_r;
  logic [7:0]         byte_r;
  logic signed [15:0] samp_r;
  logic signed [ACC_W-1:0] acc_r;
  msad_out_item_t     pend_r;
  logic               out_valid_r;
  msad_out_item_t     out_item_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r;

  msad_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // Header decode for the byte on the input.
  logic        in_acc;
  logic [15:0] hdr_len, npre, p, rel;
  logic [16:0] p1;
  logic        is_pre, is_hdr, last_hdr, hdr_ch;
  logic [14:0] q;
  logic [1:0]  field;
  logic signed [15:0] hdr_val;

  assign in_acc   = in_valid && !in_stall;
  assign hdr_len  = stereo_r ? STEREO_HDR_LEN : MONO_HDR_LEN;
  assign npre     = stereo_r ? 16'd2 : 16'd1;
  assign p        = in_data.first_of_block ? 16'd0 : pos_r;
  assign is_pre   = p < npre;
  assign is_hdr   = p < hdr_len;
  assign last_hdr = p == (hdr_len - 16'd1);
  assign rel      = p - npre;
  assign q        = rel[15:1];
  assign hdr_ch   = stereo_r & q[0];
  assign field    = stereo_r ? q[2:1] : q[1:0];
  assign hdr_val  = {in_data.data_byte, hold_r};
  assign p1       = {1'b0, p} + 17'd1;

  // Sequencer datapath.
  logic               ch;
  logic [3:0]         code;
  logic               out_free;
  logic signed [ACC_W-1:0] prod_ext, acc_sum;
  logic signed [PROD_W-9:0] d_raw;
  logic signed [31:0] d_new;
  logic signed [15:0] s_clip;

  assign ch       = stereo_r & code_idx_r;
  assign code     = code_idx_r ? byte_r[3:0] : byte_r[7:4];
  assign out_free = !out_valid_r || !out_stall;
  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign acc_sum  = acc_r + prod_ext;
  assign d_raw    = prod_r[PROD_W-1:8];

  always_comb begin
    priority if (acc_sum < SAMP_MIN) begin
      s_clip = -16'sd32768;
    end else if (acc_sum > SAMP_MAX) begin
      s_clip = 16'sd32767;
    end else begin
      s_clip = acc_sum[15:0];
    end
  end

  always_comb begin
    priority if (d_raw < DMIN) begin
      d_new = DELTA_FLOOR;
    end else if (d_raw > DMAX) begin
      d_new = 32'h7FFF_FFFF;
    end else begin
      d_new = d_raw[31:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!is_hdr) begin
            state_nxt = ST_NA;
          end else if (last_hdr) begin
            state_nxt = ST_HDR0;
          end
        end
      end
      ST_HDR0: if (out_free) state_nxt = ST_HDR1;
      ST_HDR1: if (out_free) state_nxt = ST_IDLE;
      ST_NA:   state_nxt = ST_OB;
      ST_OB:   state_nxt = ST_MD;
      ST_MD:   state_nxt = ST_TD;
      ST_TD:   state_nxt = ST_UPD;
      ST_UPD:  state_nxt = (stereo_r && !code_idx_r) ? ST_NA : ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = (!stereo_r && !code_idx_r) ? ST_NA : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  logic           emit_we;
  msad_out_item_t emit_item;

  always_comb begin
    in_stall  = 1'b1;
    emit_we   = 1'b0;
    emit_item = pend_r;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_HDR0: begin
        emit_we   = out_free;
        emit_item = '{left_sample: older_r[0],
                      right_sample: stereo_r ? older_r[1] : 16'sd0,
                      last_of_run: 1'b0};
      end
      ST_HDR1: begin
        emit_we   = out_free;
        emit_item = '{left_sample: newer_r[0],
                      right_sample: stereo_r ? newer_r[1] : 16'sd0,
                      last_of_run: 1'b1};
      end
      ST_NA: begin
        mul_a = {{(MUL_A_W-16){newer_r[ch][15]}}, newer_r[ch]};
        mul_b = coef_a(pred_r[ch]);
      end
      ST_OB: begin
        mul_a = {{(MUL_A_W-16){older_r[ch][15]}}, older_r[ch]};
        mul_b = coef_b(pred_r[ch]);
      end
      ST_MD: begin
        mul_a = delta_r[ch];
        mul_b = {{(MUL_B_W-4){code[3]}}, code};
      end
      ST_TD: begin
        mul_a = delta_r[ch];
        mul_b = adapt_step(code);
      end
      ST_UPD: begin
      end
      ST_EMIT: emit_we = out_free;
      default: begin
      end
    endcase
  end

  // Control and channel state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      stereo_r   <= 1'b0;
      align_r    <= ALIGN_RESET;
      pos_r      <= '0;
      hold_r     <= '0;
      code_idx_r <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        pred_r[i]  <= '0;
        delta_r[i] <= '0;
        newer_r[i] <= '0;
        older_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STEREO_MODE: stereo_r <= cfg_wdata[0];
          CFG_BLOCK_ALIGN: align_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        code_idx_r <= 1'b0;
        if (p1 >= {1'b0, hdr_len} && p1 >= {1'b0, align_r}) begin
          pos_r <= '0;
        end else begin
          pos_r <= p1[15:0];
        end
        if (is_pre) begin
          pred_r[p[0]] <= (in_data.data_byte > {5'd0, PRED_MAX}) ?
                          PRED_MAX : in_data.data_byte[2:0];
        end else if (is_hdr) begin
          if (!rel[0]) begin
            hold_r <= in_data.data_byte;
          end else begin
            // Each 16-bit header field lands when its high byte arrives.
            unique case (field)
              2'd0:    delta_r[hdr_ch] <= {{16{hdr_val[15]}}, hdr_val};
              2'd1:    newer_r[hdr_ch] <= hdr_val;
              default: older_r[hdr_ch] <= hdr_val;
            endcase
          end
        end
      end
      if (state_r == ST_UPD) begin
        delta_r[ch] <= d_new;
        older_r[ch] <= newer_r[ch];
        newer_r[ch] <= samp_r;
        if (stereo_r && !code_idx_r) begin
          code_idx_r <= 1'b1;
        end
      end
      if (state_r == ST_EMIT && out_free && !stereo_r && !code_idx_r) begin
        code_idx_r <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_data.data_byte;
    end
    unique case (state_r)
      ST_OB: acc_r <= prod_ext;
      ST_MD: acc_r <= acc_sum >>> 8;
      ST_TD: samp_r <= s_clip;
      ST_UPD: begin
        if (!stereo_r) begin
          pend_r <= '{left_sample: samp_r, right_sample: 16'sd0,
                      last_of_run: code_idx_r};
        end else if (!code_idx_r) begin
          pend_r.left_sample <= samp_r;
        end else begin
          pend_r.right_sample <= samp_r;
          pend_r.last_of_run  <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_we) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_we) begin
      out_item_r <= emit_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

`ifndef NO_ASSERTIONS
  a_data_starts_code: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_hdr) |=> (state_r == ST_NA))
    else $error("data byte did not start a code sequence");

  a_upd_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |=> (state_r == ST_NA || state_r == ST_EMIT))
    else $error("state update not followed by next code or emit");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_HDR0 || $past(state_r) == ST_HDR1 ||
                            $past(state_r) == ST_EMIT))
    else $error("output frame loaded outside an emit state");
`endif

endmodule
